// ===== rtl/swarq_pkg.sv =====
// ----------------------------------------------------------------------------
// swarq_pkg
// Types and constants shared by the stop-and-wait ARQ sender modules.
// ----------------------------------------------------------------------------
package swarq_pkg;

    localparam int unsigned NUM_BYTES  = 20;
    localparam int unsigned LANE_COUNT = 4;
    localparam int unsigned LANE_BYTES = NUM_BYTES / LANE_COUNT;
    localparam int unsigned LANE_SUM_W = 11;
    localparam int unsigned CHECK_W    = 13;
    localparam int unsigned TOTAL_W    = 18;
    localparam int unsigned TIMER_W    = 16;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd20;

    typedef logic [NUM_BYTES-1:0][7:0]  payload_t;
    typedef logic [LANE_BYTES-1:0][7:0] lane_bytes_t;
    typedef logic [LANE_SUM_W-1:0]      lane_sum_t;

    typedef enum logic [1:0] {
        OP_MESSAGE = 2'd0,
        OP_PACKET  = 2'd1,
        OP_TICK    = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        EV_IDLE_TICK = 3'd0,
        EV_SENT      = 3'd1,
        EV_RESENT    = 3'd2,
        EV_ACK_OK    = 3'd3,
        EV_CORRUPT   = 3'd4,
        EV_IGNORED   = 3'd5,
        EV_BUSY      = 3'd6
    } event_t;

    // Header fields of one request, held in the first stage.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] seq_number;
        logic [15:0] ack_number;
        logic [31:0] check_value;
    } req_hdr_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic               out_seq;
        logic               out_ack;
        logic [CHECK_W-1:0] out_check;
        payload_t           out_payload;
        logic               awaiting_ack;
    } result_t;

endpackage

// ===== rtl/swarq_ifs.sv =====
// ----------------------------------------------------------------------------
// swarq_req_if / swarq_rsp_if
// Valid/ready channels for requests into and results out of the sender.
// ----------------------------------------------------------------------------
interface swarq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] seq_number;
    logic [15:0] ack_number;
    logic [31:0] check_value;
    logic [63:0] payload_low;
    logic [63:0] payload_mid;
    logic [31:0] payload_high;

    modport source (
        output valid, opcode, seq_number, ack_number, check_value,
               payload_low, payload_mid, payload_high,
        input  ready
    );
    modport sink (
        input  valid, opcode, seq_number, ack_number, check_value,
               payload_low, payload_mid, payload_high,
        output ready
    );
endinterface

interface swarq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_code;
    logic        out_seq;
    logic        out_ack;
    logic [12:0] out_check;
    logic [63:0] out_payload_low;
    logic [63:0] out_payload_mid;
    logic [31:0] out_payload_high;
    logic        awaiting_ack;

    modport source (
        output valid, event_code, out_seq, out_ack, out_check,
               out_payload_low, out_payload_mid, out_payload_high, awaiting_ack,
        input  ready
    );
    modport sink (
        input  valid, event_code, out_seq, out_ack, out_check,
               out_payload_low, out_payload_mid, out_payload_high, awaiting_ack,
        output ready
    );
endinterface

// ===== rtl/swarq_lane.sv =====
// ----------------------------------------------------------------------------
// swarq_lane
// One checksum lane: masks its slice of payload bytes and registers the
// bytes together with their partial sum.
// ----------------------------------------------------------------------------
module swarq_lane
    import swarq_pkg::*;
#(
    parameter int unsigned LANE_INDEX    = 0,
    parameter int unsigned PAYLOAD_BYTES = 20
)
(
    input  logic        clk,
    input  logic        load,
    input  lane_bytes_t bytes_in,
    output lane_bytes_t bytes_reg,
    output lane_sum_t   sum_reg
);

    lane_bytes_t bytes_next;
    lane_sum_t   sum_next;

    // Bytes past the configured payload length are forced to zero.
    always_comb
    begin
        sum_next = '0;
        for (int unsigned j = 0; j < LANE_BYTES; j++)
        begin
            if (LANE_INDEX * LANE_BYTES + j < PAYLOAD_BYTES)
            begin
                bytes_next[j] = bytes_in[j];
            end
            else
            begin
                bytes_next[j] = 8'd0;
            end
            sum_next = sum_next + {3'd0, bytes_next[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= bytes_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

// ===== rtl/swarq_ctrl.sv =====
// ----------------------------------------------------------------------------
// swarq_ctrl
// Merges the lane sums, checks arriving packets and runs the sender state:
// wait flag, sequence bit, retransmission timer and the saved packet.
// ----------------------------------------------------------------------------
module swarq_ctrl
    import swarq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [TIMER_W-1:0]          cfg_wdata,
    input  logic                        fire,
    input  req_hdr_t                    hdr,
    input  payload_t                    payload,
    input  logic [LANE_COUNT-1:0][LANE_SUM_W-1:0] lane_sums,
    output result_t                     result
);

    logic               waiting_reg, waiting_next;
    logic               seq_bit_reg, seq_bit_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic [TIMER_W-1:0] timeout_reg;
    payload_t           saved_payload_reg;
    logic [CHECK_W-1:0] saved_check_reg;

    logic [CHECK_W-1:0] byte_sum;
    logic [TOTAL_W-1:0] packet_total;
    logic               check_ok;
    logic [CHECK_W-1:0] msg_check;
    logic               new_send;
    logic               sent;
    logic [2:0]         ev;

    always_comb
    begin
        byte_sum = '0;
        for (int unsigned g = 0; g < LANE_COUNT; g++)
        begin
            byte_sum = byte_sum + {{(CHECK_W - LANE_SUM_W){1'b0}}, lane_sums[g]};
        end
    end

    assign packet_total = {2'd0, hdr.seq_number} + {2'd0, hdr.ack_number}
                        + {{(TOTAL_W - CHECK_W){1'b0}}, byte_sum};
    assign check_ok     = ({{(32 - TOTAL_W){1'b0}}, packet_total} == hdr.check_value);
    assign msg_check    = byte_sum + {{(CHECK_W - 1){1'b0}}, seq_bit_reg};

    always_comb
    begin
        waiting_next = waiting_reg;
        seq_bit_next = seq_bit_reg;
        timer_next   = timer_reg;
        new_send     = 1'b0;
        sent         = 1'b0;
        ev           = EV_IGNORED;
        unique case (hdr.opcode)
            OP_MESSAGE:
            begin
                if (waiting_reg)
                begin
                    ev = EV_BUSY;
                end
                else
                begin
                    waiting_next = 1'b1;
                    timer_next   = timeout_reg;
                    new_send     = 1'b1;
                    sent         = 1'b1;
                    ev           = EV_SENT;
                end
            end
            OP_PACKET:
            begin
                if (!check_ok)
                begin
                    ev = EV_CORRUPT;
                end
                else if (waiting_reg && hdr.ack_number == {15'd0, seq_bit_reg})
                begin
                    waiting_next = 1'b0;
                    seq_bit_next = ~seq_bit_reg;
                    ev           = EV_ACK_OK;
                end
                else
                begin
                    ev = EV_IGNORED;
                end
            end
            OP_TICK:
            begin
                if (!waiting_reg)
                begin
                    ev = EV_IDLE_TICK;
                end
                else if (timer_reg <= 16'd1)
                begin
                    // A count of zero or one expires on this tick.
                    timer_next = timeout_reg;
                    sent       = 1'b1;
                    ev         = EV_RESENT;
                end
                else
                begin
                    timer_next = timer_reg - 16'd1;
                    ev         = EV_IDLE_TICK;
                end
            end
            default:
            begin
                ev = EV_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        result              = '0;
        result.event_code   = ev;
        result.awaiting_ack = waiting_next;
        if (sent)
        begin
            result.out_seq     = seq_bit_reg;
            result.out_check   = new_send ? msg_check : saved_check_reg;
            result.out_payload = new_send ? payload : saved_payload_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            seq_bit_reg <= 1'b0;
            timer_reg   <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end
        else
        begin
            if (fire)
            begin
                waiting_reg <= waiting_next;
                seq_bit_reg <= seq_bit_next;
                timer_reg   <= timer_next;
            end
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && new_send)
        begin
            saved_payload_reg <= payload;
            saved_check_reg   <= msg_check;
        end
    end

endmodule

// ===== rtl/swarq_skid.sv =====
// ----------------------------------------------------------------------------
// swarq_skid
// Two-entry output buffer: an output register plus a skid register, so a
// new result can be taken while the previous one is still stalled.
// ----------------------------------------------------------------------------
module swarq_skid
    import swarq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop       = out_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

// ===== rtl/stop_and_wait_arq_sender_unit.sv =====
// ----------------------------------------------------------------------------
// stop_and_wait_arq_sender_unit
// Alternating-bit stop-and-wait sender: frames messages, checks arriving
// acknowledgements and retransmits on timer expiry.
//
//   channel   direction  contents
//   req       in         opcode, packet header fields, 20 payload bytes
//   rsp       out        event code, emitted packet, wait status
//   cfg       in         retransmission timeout in ticks (write only)
//
// One request per cycle is accepted while req is ready; each gives one result.
// The first stage splits the checksum over four byte lanes; the second merges
// the lane sums and updates the sender state, which is what closes the loop.
// Reset clears the wait flag, sequence bit and timer and sets the timeout to
// 20. A stalled rsp is absorbed by a skid register, so req stays ready
// until both result registers are full and the first stage holds a request.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_sender_unit
    import swarq_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TIMER_W-1:0] cfg_wdata,
    swarq_req_if.sink          req,
    swarq_rsp_if.source        rsp
);

    payload_t payload_in;
    logic     load;
    logic     s1_valid_reg;
    logic     s1_fire;
    logic     skid_full;
    req_hdr_t hdr_reg;
    result_t  result;
    result_t  rsp_data;
    payload_t s1_payload;

    logic [LANE_COUNT-1:0][LANE_BYTES-1:0][7:0]  lane_bytes;
    logic [LANE_COUNT-1:0][LANE_SUM_W-1:0]       lane_sums;

    assign payload_in = {req.payload_high, req.payload_mid, req.payload_low};
    assign s1_fire    = s1_valid_reg && !skid_full;
    assign req.ready  = !s1_valid_reg || s1_fire;
    assign load       = req.valid && req.ready;
    assign s1_payload = lane_bytes;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hdr_reg.opcode      <= req.opcode;
            hdr_reg.seq_number  <= req.seq_number;
            hdr_reg.ack_number  <= req.ack_number;
            hdr_reg.check_value <= req.check_value;
        end
    end

    for (genvar g = 0; g < LANE_COUNT; g++)
    begin : g_lane
        swarq_lane #(
            .LANE_INDEX    (g),
            .PAYLOAD_BYTES (PAYLOAD_BYTES)
        ) u_lane (
            .clk       (clk),
            .load      (load),
            .bytes_in  (payload_in[g*LANE_BYTES +: LANE_BYTES]),
            .bytes_reg (lane_bytes[g]),
            .sum_reg   (lane_sums[g])
        );
    end

    swarq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (s1_fire),
        .hdr       (hdr_reg),
        .payload   (s1_payload),
        .lane_sums (lane_sums),
        .result    (result)
    );

    swarq_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_fire),
        .push_data (result),
        .full      (skid_full),
        .out_valid (rsp.valid),
        .out_data  (rsp_data),
        .out_ready (rsp.ready)
    );

    assign rsp.event_code       = rsp_data.event_code;
    assign rsp.out_seq          = rsp_data.out_seq;
    assign rsp.out_ack          = rsp_data.out_ack;
    assign rsp.out_check        = rsp_data.out_check;
    assign rsp.out_payload_low  = rsp_data.out_payload[7:0];
    assign rsp.out_payload_mid  = rsp_data.out_payload[15:8];
    assign rsp.out_payload_high = rsp_data.out_payload[19:16];
    assign rsp.awaiting_ack     = rsp_data.awaiting_ack;

endmodule
